>>> design/bhpq_pkg.sv
// Package for the binary heap priority queue: sizes, codes, state type
// and the ordering function. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bhpq_pkg;

    localparam int CAPACITY = 1024;
    localparam int VALUE_W  = 31;
    localparam int ENTRY_W  = 11;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    // Register index of the mode register on the configuration port.
    localparam logic [PADDR_W-3:0] REG_MIN_MODE = '0;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_POP    = 1'b1;

    localparam logic signed [VALUE_W-1:0] POP_EMPTY = VALUE_W'(-1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UP_RD,
        ST_UP_CMP,
        ST_POP_LAST,
        ST_POP_CAP,
        ST_DN_RDL,
        ST_DN_RDR,
        ST_DN_CMP,
        ST_RESULT
    } bhpq_state_t;

    // True when a belongs strictly above b under the current ordering.
    function automatic logic better(input logic min_mode,
                                    input logic signed [VALUE_W-1:0] a,
                                    input logic signed [VALUE_W-1:0] b);
        return min_mode ? (a < b) : (a > b);
    endfunction

    // Heap positions start at 1; memory addresses start at 0.
    function automatic logic [ADDR_W-1:0] pos_to_addr(input logic [CNT_W-1:0] p);
        logic [CNT_W-1:0] d;
        d = p - CNT_W'(1);
        return d[ADDR_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> design/binary_heap_priority_queue.sv
// Top level of the binary heap priority queue: heap memory, sift sequencer,
// result register and configuration port. Depends on bhpq_pkg.
//
// Usage: each item on the s_ channel is an insert (s_req_type = 0, value in
// s_value) or a pop (s_req_type = 1). Every item gives exactly one result on
// the m_ channel: the popped value (0 for an insert, -1 with m_empty_flag on
// a pop from an empty heap), m_full_flag when an insert was dropped, and the
// entry count after the item.
// The heap lives in a single memory with one read and one write port and a
// registered read, so every tree level costs memory reads. An insert reads
// the parent and compares at each level climbed; a pop reads the root and
// the last entry, then reads the left and right child and compares at each
// level descended. A pop from an empty heap or an insert into a full heap
// goes straight to the result.
// One item is processed at a time; s_ready is high while the sequencer is
// idle.
// The result sits in an output register, so a new item is taken while an
// earlier result is still waiting; when the receiver stalls, the sequencer
// holds its finished result until the output register frees up.
// Reset empties the heap (entry count zero) and selects min mode; the memory
// itself is not cleared, since only written entries are ever read.
// min_mode is written through the APB port at address 0; the user must write
// it only while the block is idle, which the block itself does not enforce.
`timescale 1ns / 1ps
`default_nettype none

module binary_heap_priority_queue (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // Input items
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic                                s_req_type,
    input  wire logic signed [bhpq_pkg::VALUE_W-1:0] s_value,
    // Result items
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed [bhpq_pkg::VALUE_W-1:0]      m_pop_value,
    output logic                                     m_empty_flag,
    output logic                                     m_full_flag,
    output logic [bhpq_pkg::ENTRY_W-1:0]             m_entry_count,
    // Configuration
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [bhpq_pkg::PADDR_W-1:0]        paddr,
    input  wire logic [bhpq_pkg::PDATA_W-1:0]        pwdata,
    output logic [bhpq_pkg::PDATA_W-1:0]             prdata,
    output logic                                     pready
);
    import bhpq_pkg::*;

    bhpq_state_t state_reg, state_next;

    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic [CNT_W-1:0]          pos_reg, pos_next;
    logic signed [VALUE_W-1:0] v_reg, v_next;
    logic signed [VALUE_W-1:0] left_reg, left_next;
    logic signed [VALUE_W-1:0] pop_reg, pop_next;
    logic                      empty_reg, empty_next;
    logic                      full_reg, full_next;
    logic                      min_mode_reg;

    logic                      m_valid_reg, m_valid_next;
    logic signed [VALUE_W-1:0] m_pop_reg, m_pop_next;
    logic                      m_empty_reg, m_empty_next;
    logic                      m_full_reg, m_full_next;
    logic [ENTRY_W-1:0]        m_count_reg, m_count_next;

    // Heap memory with registered read data.
    logic signed [VALUE_W-1:0] mem_ram [CAPACITY];
    logic signed [VALUE_W-1:0] rdata_reg;
    logic                      mem_re, mem_we;
    logic [ADDR_W-1:0]         raddr, waddr;
    logic signed [VALUE_W-1:0] wdata;

    logic              accept, out_free, cfg_write;
    logic              heap_empty, heap_full;
    logic [CNT_W:0]    lft, rgt;
    logic              has_l, has_r, up_move, dn_move, pick_left;

    assign accept     = s_valid && s_ready;
    assign out_free   = !m_valid_reg || m_ready;
    assign heap_empty = (cnt_reg == '0);
    assign heap_full  = (cnt_reg == CNT_W'(CAPACITY));

    assign lft       = {pos_reg, 1'b0};
    assign rgt       = {pos_reg, 1'b1};
    assign has_l     = (lft <= {1'b0, cnt_reg});
    assign has_r     = (rgt <= {1'b0, cnt_reg});
    assign up_move   = better(min_mode_reg, v_reg, rdata_reg);
    assign pick_left = !has_r || better(min_mode_reg, left_reg, rdata_reg);
    assign dn_move   = better(min_mode_reg, left_reg, v_reg) ||
                       (has_r && better(min_mode_reg, rdata_reg, v_reg));

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_pop_value   = m_pop_reg;
    assign m_empty_flag  = m_empty_reg;
    assign m_full_flag   = m_full_reg;
    assign m_entry_count = m_count_reg;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite &&
                       (paddr[PADDR_W-1:2] == REG_MIN_MODE);
    assign prdata    = (paddr[PADDR_W-1:2] == REG_MIN_MODE) ?
                       {{(PDATA_W-1){1'b0}}, min_mode_reg} : '0;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_req_type == OP_POP) begin
                        state_next = heap_empty ? ST_RESULT : ST_POP_LAST;
                    end else begin
                        state_next = heap_full ? ST_RESULT : ST_UP_RD;
                    end
                end
            end
            ST_UP_RD:    state_next = (pos_reg == CNT_W'(1)) ? ST_RESULT : ST_UP_CMP;
            ST_UP_CMP:   state_next = up_move ? ST_UP_RD : ST_RESULT;
            ST_POP_LAST: state_next = ST_POP_CAP;
            ST_POP_CAP:  state_next = ST_DN_RDL;
            ST_DN_RDL:   state_next = has_l ? ST_DN_RDR : ST_RESULT;
            ST_DN_RDR:   state_next = ST_DN_CMP;
            ST_DN_CMP:   state_next = dn_move ? ST_DN_RDL : ST_RESULT;
            ST_RESULT:   state_next = out_free ? ST_IDLE : ST_RESULT;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Datapath, memory control and result register.
    // The value being sifted rides in v_reg and is written only once it has
    // settled, so the hole it leaves is never read and no forwarding is needed.
    always_comb begin
        cnt_next     = cnt_reg;
        pos_next     = pos_reg;
        v_next       = v_reg;
        left_next    = left_reg;
        pop_next     = pop_reg;
        empty_next   = empty_reg;
        full_next    = full_reg;
        mem_re       = 1'b0;
        mem_we       = 1'b0;
        raddr        = '0;
        waddr        = pos_to_addr(pos_reg);
        wdata        = v_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_pop_next   = m_pop_reg;
        m_empty_next = m_empty_reg;
        m_full_next  = m_full_reg;
        m_count_next = m_count_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    pop_next   = '0;
                    empty_next = 1'b0;
                    full_next  = 1'b0;
                    if (s_req_type == OP_POP) begin
                        if (heap_empty) begin
                            pop_next   = POP_EMPTY;
                            empty_next = 1'b1;
                        end else begin
                            mem_re = 1'b1;
                            raddr  = pos_to_addr(CNT_W'(1));
                        end
                    end else begin
                        if (heap_full) begin
                            full_next = 1'b1;
                        end else begin
                            cnt_next = cnt_reg + CNT_W'(1);
                            pos_next = cnt_reg + CNT_W'(1);
                            v_next   = s_value;
                        end
                    end
                end
            end
            ST_UP_RD: begin
                if (pos_reg == CNT_W'(1)) begin
                    mem_we = 1'b1;
                end else begin
                    mem_re = 1'b1;
                    raddr  = pos_to_addr(pos_reg >> 1);
                end
            end
            ST_UP_CMP: begin
                mem_we = 1'b1;
                if (up_move) begin
                    wdata    = rdata_reg;
                    pos_next = pos_reg >> 1;
                end
            end
            ST_POP_LAST: begin
                pop_next = rdata_reg;
                mem_re   = 1'b1;
                raddr    = pos_to_addr(cnt_reg);
            end
            ST_POP_CAP: begin
                v_next   = rdata_reg;
                cnt_next = cnt_reg - CNT_W'(1);
                pos_next = CNT_W'(1);
            end
            ST_DN_RDL: begin
                if (has_l) begin
                    mem_re = 1'b1;
                    raddr  = pos_to_addr(lft[CNT_W-1:0]);
                end else begin
                    mem_we = 1'b1;
                end
            end
            ST_DN_RDR: begin
                left_next = rdata_reg;
                if (has_r) begin
                    mem_re = 1'b1;
                    raddr  = pos_to_addr(rgt[CNT_W-1:0]);
                end
            end
            ST_DN_CMP: begin
                mem_we = 1'b1;
                if (dn_move) begin
                    wdata    = pick_left ? left_reg : rdata_reg;
                    pos_next = pick_left ? lft[CNT_W-1:0] : rgt[CNT_W-1:0];
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_pop_next   = pop_reg;
                    m_empty_next = empty_reg;
                    m_full_next  = full_reg;
                    m_count_next = ENTRY_W'(cnt_reg);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            m_valid_reg  <= 1'b0;
            min_mode_reg <= 1'b1;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
            if (cfg_write) begin
                min_mode_reg <= pwdata[0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg     <= pos_next;
        v_reg       <= v_next;
        left_reg    <= left_next;
        pop_reg     <= pop_next;
        empty_reg   <= empty_next;
        full_reg    <= full_next;
        m_pop_reg   <= m_pop_next;
        m_empty_reg <= m_empty_next;
        m_full_reg  <= m_full_next;
        m_count_reg <= m_count_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem_ram[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_re) begin
            rdata_reg <= mem_ram[raddr];
        end
    end

endmodule

`default_nettype wire

>>> design/bhpq_checker.sv
// Port-level checker for the binary heap priority queue and its bind.
// Depends on bhpq_pkg and binary_heap_priority_queue.
`timescale 1ns / 1ps
`default_nettype none

module bhpq_checker (
    input wire logic                                aclk,
    input wire logic                                aresetn,
    input wire logic                                m_valid,
    input wire logic                                m_ready,
    input wire logic signed [bhpq_pkg::VALUE_W-1:0] m_pop_value,
    input wire logic                                m_empty_flag,
    input wire logic                                m_full_flag,
    input wire logic [bhpq_pkg::ENTRY_W-1:0]        m_entry_count
);
    import bhpq_pkg::*;

    // A result never reports both an empty pop and a dropped insert.
    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_empty_flag && m_full_flag))
        else $error("empty and full flags set together");

    // An empty pop leaves no entries and returns minus one.
    a_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_empty_flag) |-> (m_entry_count == '0 && m_pop_value == POP_EMPTY))
        else $error("empty pop with entries or wrong value");

    // A dropped insert happens only at capacity.
    a_full_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_full_flag) |->
            (m_entry_count == ENTRY_W'(CAPACITY) && m_pop_value == '0))
        else $error("full flag below capacity");

    // The entry count never exceeds the capacity.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_entry_count <= ENTRY_W'(CAPACITY)))
        else $error("entry count above capacity");

    // A stalled result stays valid and holds its pop value and entry count.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=>
            (m_valid && $stable(m_pop_value) && $stable(m_entry_count)))
        else $error("stalled result changed");

endmodule

bind binary_heap_priority_queue bhpq_checker u_bhpq_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_pop_value   (m_pop_value),
    .m_empty_flag  (m_empty_flag),
    .m_full_flag   (m_full_flag),
    .m_entry_count (m_entry_count)
);

`default_nettype wire
